// File: hdl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types, constants and the log2 table generator for the dew point
// calculator.
// ----------------------------------------------------------------------------
package dpc_pkg;

	localparam int unsigned FRAC_BITS_DEFAULT = 8;
	localparam int unsigned LOG_DEPTH_DEFAULT = 64;

	// Magnus constants in Q16
	localparam logic signed [21:0] K_A   = 22'sd1131807;   // 17.27
	localparam logic signed [24:0] K_B   = 25'sd15577907;  // 237.7
	localparam logic signed [16:0] K_LN2 = 17'sd45426;     // ln(2)

	typedef struct packed {
		logic signed [15:0] temperature;
		logic        [14:0] humidity;
	} dpc_in_t;

	typedef struct packed {
		logic signed [15:0] dew_point;
		logic               invalid_humidity;
		logic               saturated;
	} dpc_out_t;

	// log2(1 + frac/2^30) in Q30 by 30 rounds of truncated squaring
	function automatic logic [30:0] log2_frac(input logic [63:0] frac);
		logic [63:0] y;
		logic [30:0] res;
		y   = (64'd1 << 30) + frac;
		res = '0;
		for (int k = 1; k <= 30; k++) begin
			y = (y * y) >> 30;
			if (y >= (64'd2 << 30)) begin
				y = y >> 1;
				res[30 - k] = 1'b1;
			end
		end
		return res;
	endfunction

endpackage

// File: hdl/dpc_div_pipe.sv
// ----------------------------------------------------------------------------
// dpc_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband word that travels alongside the operands.
// ----------------------------------------------------------------------------
module dpc_div_pipe #(
	parameter int unsigned NUM_W  = 48,
	parameter int unsigned DEN_W  = 29,
	parameter int unsigned Q_W    = 39,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] out_side
);

	// compare width: numerator must stay below den << Q_W
	localparam int unsigned CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic              v_s    [Q_W];
	logic [Q_W-1:0]    quo_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic [NUM_W-1:0]  rem_s  [Q_W-1];
	logic [DEN_W-1:0]  den_s  [Q_W-1];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		localparam int unsigned B = Q_W - 1 - k;

		logic              v_in;
		logic [NUM_W-1:0]  rem_in;
		logic [DEN_W-1:0]  den_in;
		logic [Q_W-1:0]    quo_in;
		logic [SIDE_W-1:0] side_in;
		logic [CW-1:0]     dsh;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = num;
			assign den_in  = den;
			assign quo_in  = '0;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = v_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign den_in  = den_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign side_in = side_s[k-1];
		end

		// trial subtract of the shifted divisor
		assign dsh = CW'(den_in) << B;
		assign ge  = CW'(rem_in) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k]  <= quo_in | (Q_W'(ge) << B);
				side_s[k] <= side_in;
			end
		end

		if (k < Q_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? NUM_W'(CW'(rem_in) - dsh) : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign out_valid = v_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign out_side  = side_s[Q_W-1];

endmodule

// File: hdl/dew_point_calculator.sv
// ----------------------------------------------------------------------------
// dew_point_calculator
// Magnus dew point from temperature and relative humidity, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one temperature and one
//   humidity sample; output channel out_valid/out_ready/out_data returns the
//   dew point with an invalid-humidity flag and a saturation flag.
//   Every input transfer produces exactly one output transfer, in order.
//   From input transfer to the output register a sample passes the two
//   bit-serial divider pipelines, 39 stages for 17.27*T/(237.7+T) and
//   32 - FRAC_BITS stages for the final quotient, plus twelve stages of
//   log2 table, multiply and clamp, and then the output register.
//   Throughput is one item per cycle while the receiver does not stall.
//   The whole pipeline advances when the output register is empty or its
//   result is taken; when the receiver stalls everything holds in place and
//   in_ready drops, so nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty afterward and the
//   log2 table is constant logic, so no warm-up is needed.
// ----------------------------------------------------------------------------
module dew_point_calculator #(
	parameter int unsigned FRAC_BITS       = dpc_pkg::FRAC_BITS_DEFAULT,
	parameter int unsigned LOG_TABLE_DEPTH = dpc_pkg::LOG_DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dpc_pkg::dpc_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output dpc_pkg::dpc_out_t  out_data
);

	import dpc_pkg::*;

	localparam int unsigned SH     = 16 - FRAC_BITS;
	localparam int unsigned T16_W  = 32 - FRAC_BITS;
	localparam int unsigned NM1_W  = 21 + T16_W;
	localparam int unsigned DEN1_W = 29;
	localparam int unsigned Q1_W   = 39;
	localparam int unsigned CMP1_W = DEN1_W + Q1_W;
	localparam int unsigned IW     = $clog2(LOG_TABLE_DEPTH + 1);
	localparam int unsigned TT_W   = 30 + IW;
	localparam int unsigned LW     = 37;
	localparam int unsigned LP_W   = 54;
	localparam int unsigned LNV_W  = LP_W - 30;
	localparam int unsigned SUM_W  = 42;
	localparam int unsigned F_W    = 40;
	localparam int unsigned FA_W   = 39;
	localparam int unsigned DD_W   = 40;
	localparam int unsigned N2_W   = 62;
	localparam int unsigned Q2_W   = 32 - FRAC_BITS;
	localparam int unsigned CMP2_W = (N2_W > DD_W + Q2_W) ? N2_W : DD_W + Q2_W;

	localparam logic [23:0] H_MAX = 24'(100 << FRAC_BITS);

	// log2(100) in Q30 by the same table rule; 100 = 64 * (1 + 36/64)
	localparam longint unsigned C_X  = 64'd36 << 24;
	localparam longint unsigned C_T  = C_X * LOG_TABLE_DEPTH;
	localparam longint unsigned C_I  = C_T >> 30;
	localparam longint unsigned C_R  = C_T & ((64'd1 << 30) - 64'd1);
	localparam longint unsigned C_E0 = log2_frac((C_I << 30) / LOG_TABLE_DEPTH);
	localparam longint unsigned C_E1 = (C_I + 1 == LOG_TABLE_DEPTH) ? (64'd1 << 30) :
		log2_frac(((C_I + 1) << 30) / LOG_TABLE_DEPTH);
	localparam longint unsigned LOG100 = (64'd6 << 30) + C_E0 + (((C_E1 - C_E0) * C_R) >> 30);
	localparam longint unsigned L_OFFS = (64'(FRAC_BITS) << 30) + LOG100;

	localparam logic signed [SUM_W-1:0] F_LIM = SUM_W'(64'd1 << 38);

	typedef struct packed {
		logic                    inv;
		logic                    dpos;
		logic                    nneg;
		logic                    ovf;
		logic signed [LNV_W-1:0] lnv;
	} side1_t;

	typedef struct packed {
		logic inv;
		logic dpos;
		logic ddpos;
		logic neg;
		logic ovf;
	} side2_t;

	// log2 mantissa table, constant logic
	logic [30:0] log_tab [LOG_TABLE_DEPTH+1];

	for (genvar g = 0; g <= LOG_TABLE_DEPTH; g++) begin : g_tab
		if (g == LOG_TABLE_DEPTH) begin : g_last
			assign log_tab[g] = 31'(64'd1 << 30);
		end else begin : g_ent
			localparam longint unsigned FR = (64'(g) << 30) / LOG_TABLE_DEPTH;
			assign log_tab[g] = log2_frac(FR);
		end
	end

	logic adv;

	// stage registers
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [15:0]       t_s1;
	logic [14:0]              h_s1;
	logic                     inv_s2, inv_s3, inv_s4, inv_s5, inv_s6, inv_s7;
	logic signed [NM1_W:0]    num_s2;
	logic signed [DEN1_W:0]   den_s2;
	logic [3:0]               p_s2, p_s3;
	logic [IW-1:0]            i_s2;
	logic [29:0]              r_s2, r_s3;
	logic                     nneg_s3, nneg_s4, nneg_s5, nneg_s6, nneg_s7;
	logic [NM1_W-1:0]         nmag_s3, nmag_s4;
	logic [DEN1_W-1:0]        den_s3, den_s4, den_s5, den_s6, den_s7;
	logic                     dpos_s3, dpos_s4, dpos_s5, dpos_s6, dpos_s7;
	logic [30:0]              tab0_s3, tab1_s3;
	logic [60:0]              prod_s4;
	logic [34:0]              base_s4;
	logic                     ovf1_s4, ovf1_s5, ovf1_s6, ovf1_s7;
	logic [NM1_W-1:0]         num1_s5, num1_s6, num1_s7;
	logic signed [LW-1:0]     l_s5;
	logic signed [LP_W-1:0]   lp_s6;
	logic signed [LNV_W-1:0]  lnv_s7;

	logic                     v_s8, v_s9, v_s10, v_s11, v_s12;
	logic                     inv_s8, inv_s9, inv_s10, inv_s11, inv_s12;
	logic                     dpos_s8, dpos_s9, dpos_s10, dpos_s11, dpos_s12;
	logic signed [F_W-1:0]    f_s8;
	logic [FA_W-1:0]          fabs_s9;
	logic                     fneg_s9, fneg_s10, fneg_s11, fneg_s12;
	logic                     ddpos_s9, ddpos_s10, ddpos_s11, ddpos_s12;
	logic [DD_W-1:0]          dd_s9, dd_s10, dd_s11, dd_s12;
	logic [43:0]              pl_s10;
	logic [42:0]              ph_s10;
	logic [N2_W-1:0]          n2_s11, num2_s12;
	logic                     ovf2_s12;

	logic                     out_valid_q;
	dpc_out_t                 out_data_q;

	// divider hookups
	side1_t                   side1_in, side1_out;
	logic                     v_d1;
	logic [Q1_W-1:0]          q1_d1;
	logic [$bits(side1_t)-1:0] side1_vec;
	side2_t                   side2_in, side2_out;
	logic                     v_d2;
	logic [Q2_W-1:0]          q2_d2;
	logic [$bits(side2_t)-1:0] side2_vec;

	// advance the whole pipeline when the output register can take a result
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// stage 2: scale temperature, Magnus numerator and denominator, log2 index
	logic signed [T16_W-1:0] t16_c;
	logic signed [NM1_W:0]   ka_x, t16_x, num_c;
	logic signed [DEN1_W:0]  den_c;
	logic [3:0]              p_c;
	logic [14:0]             hn_c;
	logic [TT_W-1:0]         x_x, tt_c;
	logic                    inv_c;

	always_comb begin
		t16_c = T16_W'(t_s1) <<< SH;
		ka_x  = (NM1_W+1)'(K_A);
		t16_x = (NM1_W+1)'(t16_c);
		num_c = ka_x * t16_x;
		den_c = (DEN1_W+1)'(K_B) + (DEN1_W+1)'(t16_c);
		p_c   = '0;
		for (int b = 0; b < 15; b++) begin
			if (h_s1[b]) begin
				p_c = 4'(b);
			end
		end
		hn_c  = h_s1 << (4'd14 - p_c);
		x_x   = TT_W'({hn_c[13:0], 16'b0});
		tt_c  = x_x * TT_W'(LOG_TABLE_DEPTH);
		inv_c = (h_s1 == '0) || (24'(h_s1) > H_MAX);
	end

	// stage 3: numerator magnitude, table reads
	logic [NM1_W-1:0] nmag_c;
	logic [IW-1:0]    i1_c;

	always_comb begin
		nmag_c = num_s2[NM1_W] ? NM1_W'(-num_s2) : NM1_W'(num_s2);
		i1_c   = i_s2 + 1'b1;
	end

	// stage 4: interpolation product, quotient range check
	logic [60:0] dx, rx;
	logic        ovf1_c;

	always_comb begin
		dx     = 61'(tab1_s3 - tab0_s3);
		rx     = 61'(r_s3);
		ovf1_c = CMP1_W'(nmag_s3) >= (CMP1_W'(den_s3) << Q1_W);
	end

	// stage 6: ln scaling product
	logic signed [LP_W-1:0] lx, kx;

	always_comb begin
		lx = LP_W'(l_s5);
		kx = LP_W'(K_LN2);
	end

	// stage 7: truncate the ln term toward zero
	logic [LP_W-1:0] lpa_c;

	always_comb begin
		lpa_c = lp_s6[LP_W-1] ? (lp_s6 + LP_W'((64'd1 << 30) - 64'd1)) : lp_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= in_data.temperature;
			h_s1    <= in_data.humidity;

			inv_s2  <= inv_c;
			num_s2  <= num_c;
			den_s2  <= den_c;
			p_s2    <= p_c;
			i_s2    <= tt_c[TT_W-1:30];
			r_s2    <= tt_c[29:0];

			inv_s3  <= inv_s2;
			nneg_s3 <= num_s2[NM1_W];
			nmag_s3 <= nmag_c;
			den_s3  <= den_s2[DEN1_W-1:0];
			dpos_s3 <= !den_s2[DEN1_W] && (den_s2 != '0);
			p_s3    <= p_s2;
			tab0_s3 <= log_tab[i_s2];
			tab1_s3 <= log_tab[i1_c];
			r_s3    <= r_s2;

			inv_s4  <= inv_s3;
			nneg_s4 <= nneg_s3;
			nmag_s4 <= nmag_s3;
			den_s4  <= den_s3;
			dpos_s4 <= dpos_s3;
			ovf1_s4 <= ovf1_c;
			prod_s4 <= dx * rx;
			base_s4 <= {p_s3, 30'b0} + 35'(tab0_s3);

			inv_s5  <= inv_s4;
			nneg_s5 <= nneg_s4;
			den_s5  <= den_s4;
			dpos_s5 <= dpos_s4;
			ovf1_s5 <= ovf1_s4;
			num1_s5 <= ovf1_s4 ? '0 : nmag_s4;
			l_s5    <= LW'(base_s4) + LW'(prod_s4[60:30]) - LW'(L_OFFS);

			inv_s6  <= inv_s5;
			nneg_s6 <= nneg_s5;
			den_s6  <= den_s5;
			dpos_s6 <= dpos_s5;
			ovf1_s6 <= ovf1_s5;
			num1_s6 <= num1_s5;
			lp_s6   <= lx * kx;

			inv_s7  <= inv_s6;
			nneg_s7 <= nneg_s6;
			den_s7  <= den_s6;
			dpos_s7 <= dpos_s6;
			ovf1_s7 <= ovf1_s6;
			num1_s7 <= num1_s6;
			lnv_s7  <= lpa_c[LP_W-1:30];
		end
	end

	// first divider: |17.27 * T16| / (237.7 + T16)
	always_comb begin
		side1_in.inv  = inv_s7;
		side1_in.dpos = dpos_s7;
		side1_in.nneg = nneg_s7;
		side1_in.ovf  = ovf1_s7;
		side1_in.lnv  = lnv_s7;
	end

	dpc_div_pipe #(
		.NUM_W  (NM1_W),
		.DEN_W  (DEN1_W),
		.Q_W    (Q1_W),
		.SIDE_W ($bits(side1_t))
	) u_div_term (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s7),
		.num       (num1_s7),
		.den       (den_s7),
		.side      (side1_in),
		.out_valid (v_d1),
		.quo       (q1_d1),
		.out_side  (side1_vec)
	);

	assign side1_out = side1_t'(side1_vec);

	// stage 8: f = term1 + ln term, clamped
	logic [F_W-1:0]          t1mag_c;
	logic signed [F_W:0]     term1_c;
	logic signed [SUM_W-1:0] sum_c, fcl_c;

	always_comb begin
		t1mag_c = side1_out.ovf ? (F_W'(1) << Q1_W) : F_W'(q1_d1);
		term1_c = side1_out.nneg ? -(F_W+1)'(t1mag_c) : (F_W+1)'(t1mag_c);
		sum_c   = SUM_W'(term1_c) + SUM_W'(side1_out.lnv);
		if (sum_c > F_LIM) begin
			fcl_c = F_LIM;
		end else if (sum_c < -F_LIM) begin
			fcl_c = -F_LIM;
		end else begin
			fcl_c = sum_c;
		end
	end

	// stage 9: divisor 17.27 - f and magnitude of f
	logic signed [SUM_W-1:0] dd_c;
	logic [FA_W-1:0]         fabs_c;

	always_comb begin
		dd_c   = SUM_W'(K_A) - SUM_W'(f_s8);
		fabs_c = f_s8[F_W-1] ? FA_W'(-f_s8) : FA_W'(f_s8);
	end

	// stage 10: 237.7 * |f| split into two partial products
	logic [43:0] kbl_x, fl_x;
	logic [42:0] kbh_x, fh_x;

	always_comb begin
		kbl_x = 44'(K_B[23:0]);
		fl_x  = 44'(fabs_s9[19:0]);
		kbh_x = 43'(K_B[23:0]);
		fh_x  = 43'(fabs_s9[FA_W-1:20]);
	end

	// stage 12: quotient range check for the second divider
	logic ovf2_c;

	always_comb begin
		ovf2_c = CMP2_W'(n2_s11) >= (CMP2_W'(dd_s11) << Q2_W);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s8  <= v_d1;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			inv_s8    <= side1_out.inv;
			dpos_s8   <= side1_out.dpos;
			f_s8      <= F_W'(fcl_c);

			inv_s9    <= inv_s8;
			dpos_s9   <= dpos_s8;
			fneg_s9   <= f_s8[F_W-1];
			fabs_s9   <= fabs_c;
			ddpos_s9  <= !dd_c[SUM_W-1] && (dd_c != '0);
			dd_s9     <= dd_c[DD_W-1:0];

			inv_s10   <= inv_s9;
			dpos_s10  <= dpos_s9;
			fneg_s10  <= fneg_s9;
			ddpos_s10 <= ddpos_s9;
			dd_s10    <= dd_s9;
			pl_s10    <= kbl_x * fl_x;
			ph_s10    <= kbh_x * fh_x;

			inv_s11   <= inv_s10;
			dpos_s11  <= dpos_s10;
			fneg_s11  <= fneg_s10;
			ddpos_s11 <= ddpos_s10;
			dd_s11    <= dd_s10;
			n2_s11    <= N2_W'({ph_s10, 20'b0}) + N2_W'(pl_s10);

			inv_s12   <= inv_s11;
			dpos_s12  <= dpos_s11;
			fneg_s12  <= fneg_s11;
			ddpos_s12 <= ddpos_s11;
			dd_s12    <= dd_s11;
			ovf2_s12  <= ovf2_c;
			num2_s12  <= ovf2_c ? '0 : n2_s11;
		end
	end

	// second divider: |237.7 * f| / (17.27 - f)
	always_comb begin
		side2_in.inv   = inv_s12;
		side2_in.dpos  = dpos_s12;
		side2_in.ddpos = ddpos_s12;
		side2_in.neg   = fneg_s12;
		side2_in.ovf   = ovf2_s12;
	end

	dpc_div_pipe #(
		.NUM_W  (N2_W),
		.DEN_W  (DD_W),
		.Q_W    (Q2_W),
		.SIDE_W ($bits(side2_t))
	) u_div_dew (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s12),
		.num       (num2_s12),
		.den       (dd_s12),
		.side      (side2_in),
		.out_valid (v_d2),
		.quo       (q2_d2),
		.out_side  (side2_vec)
	);

	assign side2_out = side2_t'(side2_vec);

	// output: rescale, saturate, apply special cases in priority order
	logic [15:0] mag_c;
	dpc_out_t    res_c;

	always_comb begin
		mag_c = q2_d2[Q2_W-1:SH];
		res_c = '0;
		if (side2_out.inv) begin
			res_c.invalid_humidity = 1'b1;
		end else if (!side2_out.dpos) begin
			res_c.dew_point = 16'sh8000;
			res_c.saturated = 1'b1;
		end else if (!side2_out.ddpos) begin
			res_c.dew_point = 16'sh7fff;
			res_c.saturated = 1'b1;
		end else if (side2_out.neg) begin
			if (side2_out.ovf || (mag_c > 16'h8000)) begin
				res_c.dew_point = 16'sh8000;
				res_c.saturated = 1'b1;
			end else begin
				res_c.dew_point = 16'(16'h0 - mag_c);
			end
		end else begin
			if (side2_out.ovf || (mag_c > 16'h7fff)) begin
				res_c.dew_point = 16'sh7fff;
				res_c.saturated = 1'b1;
			end else begin
				res_c.dew_point = mag_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
